[sv/stt_pkg.sv]
// Shared types and constants for the software timer table.
// Used by stt_alu, software_timer_table and the testbench; no dependencies.
`timescale 1ns / 1ps

package stt_pkg;

    localparam int SLOTS_DEF   = 16;
    localparam int MAX_FIRES   = 16;
    localparam int FIRE_W      = $clog2(MAX_FIRES + 1);
    localparam int US_PER_MS   = 1000;
    localparam logic [31:0] MIN_DELAY_RST = 32'd1000;
    localparam logic [31:0] MAX_DELAY_RST = 32'd100000;

    // x / 1000 == ((x >> 3) * DIV_MUL) >> DIV_SHIFT, exact for 32-bit x
    localparam logic [31:0] DIV_MUL   = 32'd549755814;
    localparam int          DIV_SHIFT = 36;
    localparam int          WAIT_W    = 23;

    // operation codes (input tuser)
    localparam logic [1:0] OP_CREATE_PER = 2'd0;
    localparam logic [1:0] OP_CREATE_ONE = 2'd1;
    localparam logic [1:0] OP_CANCEL     = 2'd2;
    localparam logic [1:0] OP_POLL       = 2'd3;

    // result kinds (output tuser)
    localparam logic [1:0] KIND_CREATED = 2'd0;
    localparam logic [1:0] KIND_FIRED   = 2'd1;
    localparam logic [1:0] KIND_WAIT    = 2'd2;
    localparam logic [1:0] KIND_FULL    = 2'd3;

    // configuration register indexes
    localparam logic REG_MIN_DELAY = 1'b0;
    localparam logic REG_MAX_DELAY = 1'b1;

    typedef struct packed {
        logic        periodic;
        logic [31:0] interval_ms;
        logic [63:0] deadline_us;
    } t_entry;

    // operands for the shared multiply / saturating-add unit
    typedef struct packed {
        logic [31:0] mul_a;
        logic [31:0] mul_b;
        logic [63:0] add_a;
        logic [63:0] add_b;
    } t_alu_req;

endpackage

[sv/software_timer_table.sv]
// Software timer table top level: sequencer, slot valid bits, output register.
// Depends on stt_pkg, stt_ram and stt_alu.
`timescale 1ns / 1ps
//
// Usage:
//   Requests enter on the s_axis channel: tuser is the operation (create
//   periodic, create one-shot, cancel, poll), tdata holds slot, interval_ms
//   and now_us. Results leave on m_axis: tuser is the kind (created, fired,
//   wait, full), tdata holds slot_id and wait_ms, tlast marks the final result
//   of a request. A cancel gives no result.
//   Configuration: i_cfg_wr_en writes i_cfg_wdata to min (index 0) or max
//   (index 1) delay; write only while the block is idle.
// Timing: one request at a time; s_axis_tready is high only when the sequencer
//   is idle. A cancel completes in the idle state. A create runs S_FIND, S_CMUL,
//   S_CADD and S_CWR; the free search in S_FIND checks one slot per cycle up to
//   the lowest free slot. A poll visits each slot in S_PRD; an armed slot goes on
//   to S_PEV and a periodic re-arm adds S_PMUL, S_PADD and S_PWR; S_CLO, S_CHI,
//   S_DIF, S_DIV and S_WAIT then clamp, divide and give the wait result; the
//   registered shared multiplier, adder and slot RAM read port set these steps.
// Reset: all slots free, delays back to 1000 us and 100000 us; no clearing pass.
// Stall: results sit in an output register; the sequencer holds while it is
//   full and not taken, and a new request is taken while it still waits.
//
module software_timer_table #(
    parameter int SLOTS = stt_pkg::SLOTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // tuser: operation[1:0]
    // tdata: slot[3:0], interval_ms[35:4], now_us[99:36], zero[103:100]
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,
    // tuser: kind[1:0]
    // tdata: slot_id[3:0], wait_ms[26:4], zero[31:27]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         i_cfg_wr_en,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_wdata
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EW = $bits(stt_pkg::t_entry);
    localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

    typedef enum logic [15:0] {
        S_IDLE = 16'h0001,
        S_FIND = 16'h0002,
        S_CMUL = 16'h0004,
        S_CADD = 16'h0008,
        S_CWR  = 16'h0010,
        S_FULL = 16'h0020,
        S_PRD  = 16'h0040,
        S_PEV  = 16'h0080,
        S_PMUL = 16'h0100,
        S_PADD = 16'h0200,
        S_PWR  = 16'h0400,
        S_CLO  = 16'h0800,
        S_CHI  = 16'h1000,
        S_DIF  = 16'h2000,
        S_DIV  = 16'h4000,
        S_WAIT = 16'h8000
    } t_state;

    t_state r_state, n_state;
    logic [SLOTS-1:0] r_active, n_active;
    logic [31:0] r_min, r_max;

    logic [1:0]  r_op, n_op;
    logic [31:0] r_ms, n_ms;
    logic [63:0] r_now, n_now;
    logic [SW-1:0] r_idx, n_idx;
    logic [stt_pkg::FIRE_W-1:0] r_n, n_n;
    logic [63:0] r_nearest, n_nearest;
    logic r_any, n_any;
    logic r_lo, n_lo;
    logic [31:0] r_diff, n_diff;

    logic r_ovalid;
    logic [1:0] r_okind;
    logic [3:0] r_oslot;
    logic [stt_pkg::WAIT_W-1:0] r_owait;
    logic r_olast;

    logic w_out_free;
    logic w_emit;
    logic [1:0] w_ekind;
    logic [3:0] w_eslot;
    logic [stt_pkg::WAIT_W-1:0] w_ewait;
    logic w_elast;

    logic w_ram_we;
    stt_pkg::t_entry w_wentry, w_rd;
    logic [EW-1:0] w_rdata;

    stt_pkg::t_alu_req w_req;
    logic [63:0] w_prod, w_sum;
    logic w_due, w_hi;

    stt_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_idx),
        .i_wdata (w_wentry),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    stt_alu u_alu (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_prod (w_prod),
        .o_sum  (w_sum)
    );

    assign w_rd          = stt_pkg::t_entry'(w_rdata);
    assign w_out_free    = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_due = (r_n < stt_pkg::FIRE_W'(stt_pkg::MAX_FIRES)) &&
                   (r_now >= w_rd.deadline_us);
    assign w_hi  = (r_nearest > w_sum);

    always_comb begin
        n_state   = r_state;
        n_active  = r_active;
        n_op      = r_op;
        n_ms      = r_ms;
        n_now     = r_now;
        n_idx     = r_idx;
        n_n       = r_n;
        n_nearest = r_nearest;
        n_any     = r_any;
        n_lo      = r_lo;
        n_diff    = r_diff;

        w_emit  = 1'b0;
        w_ekind = stt_pkg::KIND_CREATED;
        w_eslot = '0;
        w_ewait = '0;
        w_elast = 1'b0;

        w_ram_we = 1'b0;
        w_wentry = w_rd;

        w_req.mul_a = r_ms;
        w_req.mul_b = 32'(stt_pkg::US_PER_MS);
        w_req.add_a = r_now;
        w_req.add_b = w_prod;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op      = s_axis_tuser;
                    n_ms      = s_axis_tdata[35:4];
                    n_now     = s_axis_tdata[99:36];
                    n_idx     = '0;
                    n_n       = '0;
                    n_nearest = '1;
                    n_any     = 1'b0;
                    case (s_axis_tuser)
                        stt_pkg::OP_CREATE_PER, stt_pkg::OP_CREATE_ONE: begin
                            n_state = S_FIND;
                        end
                        stt_pkg::OP_CANCEL: begin
                            for (int i = 0; i < SLOTS; i++) begin
                                if (32'(s_axis_tdata[3:0]) == 32'(i)) begin
                                    n_active[i] = 1'b0;
                                end
                            end
                        end
                        stt_pkg::OP_POLL: begin
                            n_state = S_PRD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FIND: begin
                if (!r_active[r_idx]) begin
                    n_state = S_CMUL;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_FULL;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_CMUL: begin
                n_state = S_CADD;
            end
            S_CADD: begin
                n_state = S_CWR;
            end
            S_CWR: begin
                if (w_out_free) begin
                    w_ram_we             = 1'b1;
                    w_wentry.periodic    = (r_op == stt_pkg::OP_CREATE_PER);
                    w_wentry.interval_ms = r_ms;
                    w_wentry.deadline_us = w_sum;
                    n_active[r_idx]      = 1'b1;
                    w_emit  = 1'b1;
                    w_ekind = stt_pkg::KIND_CREATED;
                    w_eslot = 4'(r_idx);
                    w_elast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FULL: begin
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    w_ekind = stt_pkg::KIND_FULL;
                    w_elast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_PRD: begin
                // free slot: skip; armed slot: read data shows next cycle
                if (r_active[r_idx]) begin
                    n_state = S_PEV;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_CLO;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_PEV: begin
                if (w_due) begin
                    if (w_out_free) begin
                        w_emit  = 1'b1;
                        w_ekind = stt_pkg::KIND_FIRED;
                        w_eslot = 4'(r_idx);
                        n_n     = r_n + 1'b1;
                        if (w_rd.periodic && (w_rd.interval_ms != '0)) begin
                            n_state = S_PMUL;
                        end else begin
                            n_active[r_idx] = 1'b0;
                            if (r_idx == LAST_IDX) begin
                                n_state = S_CLO;
                            end else begin
                                n_idx   = r_idx + 1'b1;
                                n_state = S_PRD;
                            end
                        end
                    end
                end else begin
                    n_any = 1'b1;
                    if (w_rd.deadline_us < r_nearest) begin
                        n_nearest = w_rd.deadline_us;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_CLO;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_PRD;
                    end
                end
            end
            S_PMUL: begin
                w_req.mul_a = w_rd.interval_ms;
                n_state     = S_PADD;
            end
            S_PADD: begin
                n_state = S_PWR;
            end
            S_PWR: begin
                // re-arm; read port still shows this slot's old entry
                w_ram_we             = 1'b1;
                w_wentry.deadline_us = w_sum;
                n_any                = 1'b1;
                if (w_sum < r_nearest) begin
                    n_nearest = w_sum;
                end
                if (r_idx == LAST_IDX) begin
                    n_state = S_CLO;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_PRD;
                end
            end
            S_CLO: begin
                w_req.add_b = {32'd0, r_min};
                n_state     = S_CHI;
            end
            S_CHI: begin
                n_lo        = (r_nearest < w_sum);
                w_req.add_b = {32'd0, r_max};
                n_state     = S_DIF;
            end
            S_DIF: begin
                // lower clamp is tested first; the difference fits 32 bits here
                if (!r_any) begin
                    n_diff = r_max;
                end else if (r_lo) begin
                    n_diff = r_min;
                end else if (w_hi) begin
                    n_diff = r_max;
                end else begin
                    n_diff = r_nearest[31:0] - r_now[31:0];
                end
                n_state = S_DIV;
            end
            S_DIV: begin
                w_req.mul_a = {3'd0, r_diff[31:3]};
                w_req.mul_b = stt_pkg::DIV_MUL;
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    w_ekind = stt_pkg::KIND_WAIT;
                    w_ewait = w_prod[stt_pkg::DIV_SHIFT +: stt_pkg::WAIT_W];
                    w_elast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= '0;
            r_ovalid <= 1'b0;
            r_min    <= stt_pkg::MIN_DELAY_RST;
            r_max    <= stt_pkg::MAX_DELAY_RST;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    stt_pkg::REG_MIN_DELAY: r_min <= i_cfg_wdata;
                    stt_pkg::REG_MAX_DELAY: r_max <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_ms      <= n_ms;
        r_now     <= n_now;
        r_idx     <= n_idx;
        r_n       <= n_n;
        r_nearest <= n_nearest;
        r_any     <= n_any;
        r_lo      <= n_lo;
        r_diff    <= n_diff;
        if (w_emit) begin
            r_okind <= w_ekind;
            r_oslot <= w_eslot;
            r_owait <= w_ewait;
            r_olast <= w_elast;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tdata  = {5'd0, r_owait, r_oslot};
    assign m_axis_tlast  = r_olast;

    a_fire_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_n <= stt_pkg::FIRE_W'(stt_pkg::MAX_FIRES)))
        else $error("poll fired more than the fire limit");

    a_fire_not_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_okind == stt_pkg::KIND_FIRED)) |-> !r_olast)
        else $error("fire result marked last");

    a_wait_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_okind == stt_pkg::KIND_WAIT)) |->
        (r_owait <= stt_pkg::WAIT_W'(4294967)))
        else $error("wait result out of range");

    a_wait_ends : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT && w_out_free) |=>
        (r_state == S_IDLE && r_ovalid && r_olast))
        else $error("wait report did not end the poll");

    a_create_arms : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CWR && w_out_free) |=> r_active[$past(r_idx)])
        else $error("created slot not marked active");

endmodule

[sv/stt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                    i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                    o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/stt_alu.sv]
// Shared arithmetic unit: one 32x32 multiplier and one 64-bit saturating adder,
// both registered. Depends on stt_pkg.
`timescale 1ns / 1ps

module stt_alu (
    input  logic             i_clk,
    input  stt_pkg::t_alu_req i_req,
    output logic [63:0]      o_prod,
    output logic [63:0]      o_sum
);

    logic [63:0] r_prod;
    logic [63:0] r_sum;
    logic [64:0] w_sum;

    assign w_sum = {1'b0, i_req.add_a} + {1'b0, i_req.add_b};

    always_ff @(posedge i_clk) begin
        r_prod <= i_req.mul_a * i_req.mul_b;
        // clip to all ones on carry out
        r_sum  <= w_sum[64] ? '1 : w_sum[63:0];
    end

    assign o_prod = r_prod;
    assign o_sum  = r_sum;

endmodule

[verif/software_timer_table_tb.sv]
// Self-checking testbench for software_timer_table: create, cancel and poll requests.
// Depends on stt_pkg and the software_timer_table RTL with its stt_ram and stt_alu.
`timescale 1ns / 1ps

module software_timer_table_tb;

    localparam int          NSLOT       = 16;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          SETTLE      = 120;
    localparam int          HOLD_CYCLES = 400;
    localparam int          PHASE_REQS  = 40;
    localparam logic [63:0] TIME_MAX    = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot_id;
        logic [22:0] wait_ms;
        logic        last;
    } t_timer_res;

    typedef struct {
        logic [1:0]  op;
        logic [3:0]  slot;
        logic [31:0] interval_ms;
        logic [63:0] now_us;
        int          reps;
        bit          typed;
        t_timer_res  want;
    } t_timer_req_row;

    localparam t_timer_res NO_RES = '0;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         i_cfg_wr_en;
    logic         i_cfg_index;
    logic [31:0]  i_cfg_wdata;

    software_timer_table i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Timer table as the block should hold it
    bit          slot_on  [NSLOT];
    bit          slot_per [NSLOT];
    logic [31:0] slot_iv  [NSLOT];
    logic [63:0] slot_due [NSLOT];
    logic [31:0] clamp_lo;
    logic [31:0] clamp_hi;

    t_timer_res  pending_results[$];
    t_timer_res  got_res;
    t_timer_res  want_res;

    int          err_count;
    int          req_count;
    int          n_created, n_fired, n_wait, n_full;
    int          cycle_count;
    int          idle_pct;
    int          stall_pct;
    int          hold_left;
    logic [63:0] sim_now_us;

    t_timer_req_row dir_rows[15] = '{
        '{stt_pkg::OP_POLL,       4'd0,  32'd0,        64'd0,     1,  1'b1,
          '{stt_pkg::KIND_WAIT, 4'd0, 23'd100, 1'b1}},
        '{stt_pkg::OP_CREATE_PER, 4'd0,  32'd0,        64'd0,     1,  1'b1,
          '{stt_pkg::KIND_CREATED, 4'd0, 23'd0, 1'b1}},
        '{stt_pkg::OP_CREATE_ONE, 4'd0,  32'hFFFFFFFF, TIME_MAX,  1,  1'b1,
          '{stt_pkg::KIND_CREATED, 4'd1, 23'd0, 1'b1}},
        '{stt_pkg::OP_CREATE_PER, 4'd0,  32'd5,        64'd1000,  1,  1'b1,
          '{stt_pkg::KIND_CREATED, 4'd2, 23'd0, 1'b1}},
        // zero-interval periodic slot fires and frees
        '{stt_pkg::OP_POLL,       4'd0,  32'd0,        64'd0,     1,  1'b0, NO_RES},
        // cancel of a free slot
        '{stt_pkg::OP_CANCEL,     4'd15, 32'd0,        64'd0,     1,  1'b0, NO_RES},
        '{stt_pkg::OP_POLL,       4'd0,  32'd0,        64'd6000,  1,  1'b0, NO_RES},
        // deadline nearer than the lower clamp
        '{stt_pkg::OP_POLL,       4'd0,  32'd0,        64'd10500, 1,  1'b0, NO_RES},
        '{stt_pkg::OP_CREATE_ONE, 4'd0,  32'd0,        64'd20000, 14, 1'b0, NO_RES},
        '{stt_pkg::OP_CREATE_PER, 4'd7,  32'd9,        64'd20000, 1,  1'b1,
          '{stt_pkg::KIND_FULL, 4'd0, 23'd0, 1'b1}},
        // many due slots in one poll
        '{stt_pkg::OP_POLL,       4'd0,  32'd0,        64'd20000, 1,  1'b0, NO_RES},
        '{stt_pkg::OP_CANCEL,     4'd1,  32'd0,        64'd0,     1,  1'b0, NO_RES},
        // saturated re-arm
        '{stt_pkg::OP_POLL,       4'd0,  32'd0,        TIME_MAX,  1,  1'b0, NO_RES},
        '{stt_pkg::OP_CANCEL,     4'd2,  32'd0,        64'd0,     1,  1'b0, NO_RES},
        '{stt_pkg::OP_POLL,       4'd0,  32'd0,        TIME_MAX,  1,  1'b1,
          '{stt_pkg::KIND_WAIT, 4'd0, 23'd100, 1'b1}}
    };

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? TIME_MAX : s[63:0];
    endfunction

    // Apply one request to the table; queue its results when record is set
    function automatic void predict_timer_req(input logic [1:0] op, input logic [3:0] sel,
                                              input logic [31:0] ms, input logic [63:0] now,
                                              input bit record);
        int          fires;
        bit          any_on;
        bit          placed;
        logic [63:0] nearest;
        logic [63:0] diff;
        t_timer_res  r;
        fires   = 0;
        any_on  = 1'b0;
        placed  = 1'b0;
        nearest = TIME_MAX;
        r       = '0;
        if (op == stt_pkg::OP_CREATE_PER || op == stt_pkg::OP_CREATE_ONE) begin
            for (int i = 0; i < NSLOT; i++) begin
                if (!placed && !slot_on[i]) begin
                    placed      = 1'b1;
                    slot_on[i]  = 1'b1;
                    slot_per[i] = (op == stt_pkg::OP_CREATE_PER);
                    slot_iv[i]  = ms;
                    slot_due[i] = add_sat(now, {32'd0, ms} * 64'd1000);
                    r.kind      = stt_pkg::KIND_CREATED;
                    r.slot_id   = 4'(i);
                end
            end
            if (!placed)
                r.kind = stt_pkg::KIND_FULL;
            r.last = 1'b1;
            if (record)
                pending_results.push_back(r);
        end else if (op == stt_pkg::OP_CANCEL) begin
            slot_on[sel] = 1'b0;
        end else begin
            for (int i = 0; i < NSLOT; i++) begin
                if (slot_on[i]) begin
                    if (fires < stt_pkg::MAX_FIRES && now >= slot_due[i]) begin
                        r.kind    = stt_pkg::KIND_FIRED;
                        r.slot_id = 4'(i);
                        r.wait_ms = '0;
                        r.last    = 1'b0;
                        if (record)
                            pending_results.push_back(r);
                        fires++;
                        if (slot_per[i] && slot_iv[i] != 0)
                            slot_due[i] = add_sat(now, {32'd0, slot_iv[i]} * 64'd1000);
                        else
                            slot_on[i] = 1'b0;
                    end
                    if (slot_on[i]) begin
                        any_on = 1'b1;
                        if (slot_due[i] < nearest)
                            nearest = slot_due[i];
                    end
                end
            end
            if (!any_on)
                diff = {32'd0, clamp_hi};
            else if (nearest < add_sat(now, {32'd0, clamp_lo}))
                diff = {32'd0, clamp_lo};
            else if (nearest > add_sat(now, {32'd0, clamp_hi}))
                diff = {32'd0, clamp_hi};
            else
                diff = nearest - now;
            r.kind    = stt_pkg::KIND_WAIT;
            r.slot_id = '0;
            r.wait_ms = 23'(diff / 64'd1000);
            r.last    = 1'b1;
            if (record)
                pending_results.push_back(r);
        end
    endfunction

    task automatic report_err(input string msg);
        err_count++;
        if (err_count <= 40)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Offer one request; entered and left at a falling edge
    task automatic send_req(input logic [1:0] op, input logic [3:0] sel,
                            input logic [31:0] ms, input logic [63:0] now,
                            input bit typed, input t_timer_res want);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_axis_tuser  = op;
        s_axis_tdata  = {4'd0, now, ms, sel};
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        req_count++;
        predict_timer_req(op, sel, ms, now, !typed);
        if (typed)
            pending_results.push_back(want);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        if (idx == stt_pkg::REG_MIN_DELAY)
            clamp_lo = val;
        else
            clamp_hi = val;
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_mode(input int sender_idle, input int recv_stall);
        @(posedge i_clk);
        idle_pct  = sender_idle;
        stall_pct = recv_stall;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_interval();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return $urandom;
            2:       return $urandom_range(0, 1000);
            default: return $urandom_range(1, 20);
        endcase
    endfunction

    function automatic logic [63:0] pick_now();
        sim_now_us += $urandom_range(0, 8000);
        case ($urandom_range(0, 19))
            0:       return {$urandom, $urandom};
            1:       return TIME_MAX - $urandom_range(0, 50000);
            2:       return sim_now_us - $urandom_range(0, 20000);
            default: return sim_now_us;
        endcase
    endfunction

    task automatic send_random_req();
        int          pick;
        logic [1:0]  op;
        pick = $urandom_range(0, 99);
        if (pick < 28)
            op = stt_pkg::OP_CREATE_PER;
        else if (pick < 52)
            op = stt_pkg::OP_CREATE_ONE;
        else if (pick < 67)
            op = stt_pkg::OP_CANCEL;
        else
            op = stt_pkg::OP_POLL;
        send_req(op, 4'($urandom_range(0, 15)), pick_interval(), pick_now(), 1'b0, NO_RES);
    endtask

    // Receiver side: random stalls, or a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_res = '{kind: m_axis_tuser, slot_id: m_axis_tdata[3:0],
                        wait_ms: m_axis_tdata[26:4], last: m_axis_tlast};
            if (pending_results.size() == 0) begin
                report_err($sformatf("result with nothing pending: kind %0d slot %0d",
                                     got_res.kind, got_res.slot_id));
            end else begin
                want_res = pending_results.pop_front();
                if (got_res.kind != want_res.kind)
                    report_err($sformatf("kind %0d, want %0d", got_res.kind, want_res.kind));
                if (got_res.slot_id != want_res.slot_id)
                    report_err($sformatf("slot_id %0d, want %0d",
                                         got_res.slot_id, want_res.slot_id));
                if (got_res.wait_ms != want_res.wait_ms)
                    report_err($sformatf("wait_ms %0d, want %0d",
                                         got_res.wait_ms, want_res.wait_ms));
                if (got_res.last != want_res.last)
                    report_err($sformatf("last %0b, want %0b", got_res.last, want_res.last));
                case (want_res.kind)
                    stt_pkg::KIND_CREATED: n_created++;
                    stt_pkg::KIND_FIRED:   n_fired++;
                    stt_pkg::KIND_WAIT:    n_wait++;
                    default:               n_full++;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    logic [31:0] phase_lo[6];
    logic [31:0] phase_hi[6];

    initial begin
        int sent;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = 1'b0;
        i_cfg_wdata   = '0;
        err_count     = 0;
        req_count     = 0;
        n_created     = 0;
        n_fired       = 0;
        n_wait        = 0;
        n_full        = 0;
        cycle_count   = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_left     = 0;
        sim_now_us    = 64'd100000;
        clamp_lo      = stt_pkg::MIN_DELAY_RST;
        clamp_hi      = stt_pkg::MAX_DELAY_RST;
        for (int i = 0; i < NSLOT; i++) begin
            slot_on[i]  = 1'b0;
            slot_per[i] = 1'b0;
            slot_iv[i]  = '0;
            slot_due[i] = '0;
        end
        // clamp extremes: both zero, reset, all ones, crossed, wide, random
        phase_lo = '{32'd0, stt_pkg::MIN_DELAY_RST, 32'hFFFFFFFF, 32'd50000, 32'd0,
                     32'($urandom_range(0, 20000))};
        phase_hi = '{32'd0, stt_pkg::MAX_DELAY_RST, 32'hFFFFFFFF, 32'd2000, 32'hFFFFFFFF,
                     32'($urandom_range(0, 300000))};

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        set_mode(0, 0);
        foreach (dir_rows[r]) begin
            for (int k = 0; k < dir_rows[r].reps; k++)
                send_req(dir_rows[r].op, dir_rows[r].slot, dir_rows[r].interval_ms,
                         dir_rows[r].now_us, dir_rows[r].typed, dir_rows[r].want);
        end
        drain();

        for (int p = 0; p < 6; p++) begin
            write_reg(stt_pkg::REG_MIN_DELAY, phase_lo[p]);
            write_reg(stt_pkg::REG_MAX_DELAY, phase_hi[p]);
            case (p % 4)
                0:       set_mode(0, 0);
                1:       set_mode(45, 0);
                2:       set_mode(0, 45);
                default: set_mode(20, 20);
            endcase
            if (p == 0) begin
                // long receiver hold-off while requests keep coming
                @(posedge i_clk);
                hold_left = HOLD_CYCLES;
                @(negedge i_clk);
            end
            sent = 0;
            while (sent < PHASE_REQS) begin
                if ($urandom_range(0, 24) == 0) begin
                    // burst of creates to reach a full table
                    repeat (17) begin
                        send_req($urandom_range(0, 1) ? stt_pkg::OP_CREATE_PER
                                                      : stt_pkg::OP_CREATE_ONE,
                                 4'($urandom_range(0, 15)), pick_interval(), pick_now(),
                                 1'b0, NO_RES);
                        sent++;
                    end
                end else begin
                    send_random_req();
                    sent++;
                end
            end
            drain();
        end

        if (pending_results.size() != 0)
            report_err($sformatf("%0d results never arrived", pending_results.size()));
        $display("Covered %0d requests over six clamp settings; %0d created, %0d fired,",
                 req_count, n_created, n_fired);
        $display("%0d wait reports, %0d table-full, %0d mismatches, one %0d-cycle hold-off",
                 n_wait, n_full, err_count, HOLD_CYCLES);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
sv/stt_pkg.sv
sv/stt_ram.sv
sv/stt_alu.sv
sv/software_timer_table.sv
verif/software_timer_table_tb.sv
